// ===== hdl/wildcard_star_regex_matcher_assert.svh =====
// Assertion macros shared by the matcher modules.
`ifndef WILDCARD_STAR_REGEX_MATCHER_ASSERT_SVH
`define WILDCARD_STAR_REGEX_MATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define WSRM_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wsrm check failed");
`define WSRM_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("wsrm forbidden condition seen");
`else
`define WSRM_CHECK(label, clk, rst, prop)
`define WSRM_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hdl/wsrm_pkg.sv =====
// Types and constants shared by the matcher modules.
package wsrm_pkg;

   // Input command codes
   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_TEXT    = 2'd3
   } cmd_type;

   // Row operation selected by the front end
   typedef enum logic [1:0] {
      ROW_START = 2'b01,
      ROW_STEP  = 2'b10
   } row_op_type;

   // Status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_STAR = 2'd2;

   // Special pattern bytes
   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;

   // Channel widths
   localparam int CH_W       = 8;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int COUNT_W    = 6;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Classified item passed from front to back
   typedef struct packed {
      row_op_type      op;
      logic            store_wr;
      logic            lead;
      logic [1:0]      status;
      logic [CH_W-1:0] ch;
   } item_type;

endpackage

// ===== hdl/wsrm_front.sv =====
// Front end: accepts commands, tracks pattern length and classifies items.
module wsrm_front #(
   parameter int MAX_PATTERN = 32,
   parameter int LEN_W       = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // ch
   input  logic [1:0]              req_tuser,   // cmd
   input  logic                    q_full,
   output logic                    push,
   output wsrm_pkg::item_type      push_item,
   output logic [LEN_W-1:0]        push_len
);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             lead_ff, lead_in;
   logic             full_drop;
   wsrm_pkg::cmd_type cmd;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign cmd        = wsrm_pkg::cmd_type'(req_tuser);

   // Decode the command and work out the new pattern length
   always_comb begin
      len_in             = len_ff;
      lead_in            = lead_ff;
      full_drop          = 1'b0;
      push_item.op       = wsrm_pkg::ROW_START;
      push_item.store_wr = 1'b0;
      push_item.ch       = req_tdata;
      unique case (cmd)
         wsrm_pkg::CMD_CLEAR: begin
            len_in  = '0;
            lead_in = 1'b0;
         end
         wsrm_pkg::CMD_APPEND: begin
            if (len_ff < LEN_W'(MAX_PATTERN)) begin
               if (len_ff == '0) begin
                  lead_in = (req_tdata == wsrm_pkg::STAR_BYTE);
               end
               len_in             = len_ff + LEN_W'(1);
               push_item.store_wr = 1'b1;
            end else begin
               full_drop = 1'b1;
            end
         end
         wsrm_pkg::CMD_RESTART: begin
            push_item.op = wsrm_pkg::ROW_START;
         end
         wsrm_pkg::CMD_TEXT: begin
            push_item.op = wsrm_pkg::ROW_STEP;
         end
      endcase
      push_item.lead = lead_in;
      if (full_drop) begin
         push_item.status = wsrm_pkg::STATUS_FULL;
      end else if (lead_in) begin
         push_item.status = wsrm_pkg::STATUS_STAR;
      end else begin
         push_item.status = wsrm_pkg::STATUS_OK;
      end
      push_len = len_in;
   end

   // Commit length and leading-star flag on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         lead_ff <= 1'b0;
      end else if (push) begin
         len_ff  <= len_in;
         lead_ff <= lead_in;
      end
   end

endmodule

// ===== hdl/wsrm_queue.sv =====
// Short register queue between the front end and the row engine.
`include "wildcard_star_regex_matcher_assert.svh"
module wsrm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);

   localparam int DEPTH = wsrm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_data = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `WSRM_NEVER(a_queue_overflow, clock, reset, push && full && !pop)
   `WSRM_NEVER(a_queue_underflow, clock, reset, pop && empty)
   `WSRM_CHECK(a_queue_count, clock, reset, count_ff <= CNT_W'(DEPTH))

endmodule

// ===== hdl/wsrm_back.sv =====
// Row engine: holds the pattern and match row, updates the row per item.
`include "wildcard_star_regex_matcher_assert.svh"
module wsrm_back #(
   parameter int MAX_PATTERN = 32,
   parameter int LEN_W       = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  wsrm_pkg::item_type      head,
   input  logic [LEN_W-1:0]        head_len,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata    // matched, status[1:0], pattern_count[5:0]
);

   localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEVELS = $clog2(MAX_PATTERN + 1);

   logic [7:0]         pat_ff  [MAX_PATTERN];
   logic [7:0]         pat_eff [MAX_PATTERN];
   logic [MAX_PATTERN:0] row_ff, row_in;
   logic [MAX_PATTERN:0] g_lv [LEVELS + 1];
   logic [MAX_PATTERN:0] p_lv [LEVELS + 1];
   logic [PIDX_W-1:0]  widx;
   logic [LEN_W+5:0]   count_ext;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_matched_ff;
   logic [1:0]         rsp_status_ff;
   logic [5:0]         rsp_count_ff;

   assign pop        = !q_empty && (!rsp_valid_ff || rsp_tready);
   assign widx       = PIDX_W'(head_len - LEN_W'(1));
   assign count_ext  = {6'b0, head_len};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_status_ff, rsp_matched_ff};

   // Build per-position generate/propagate, then resolve star chains by prefix
   always_comb begin
      logic hit;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_eff[i] = (head.store_wr && widx == PIDX_W'(i)) ? head.ch : pat_ff[i];
      end
      g_lv[0] = '0;
      p_lv[0] = '0;
      hit     = 1'b0;
      unique case (head.op)
         wsrm_pkg::ROW_START: begin
            g_lv[0][0] = 1'b1;
            for (int j = 2; j <= MAX_PATTERN; j++) begin
               p_lv[0][j] = (pat_eff[j-1] == wsrm_pkg::STAR_BYTE);
            end
         end
         wsrm_pkg::ROW_STEP: begin
            for (int j = 1; j <= MAX_PATTERN; j++) begin
               if (pat_eff[j-1] == wsrm_pkg::STAR_BYTE) begin
                  if (j >= 2) begin
                     hit = (pat_eff[j-2] == wsrm_pkg::DOT_BYTE) || (pat_eff[j-2] == head.ch);
                     g_lv[0][j] = hit && row_ff[j];
                     p_lv[0][j] = 1'b1;
                  end
               end else begin
                  hit = (pat_eff[j-1] == wsrm_pkg::DOT_BYTE) || (pat_eff[j-1] == head.ch);
                  g_lv[0][j] = hit && row_ff[j-1];
               end
            end
         end
         default: begin
            g_lv[0] = '0;
         end
      endcase
      for (int l = 0; l < LEVELS; l++) begin
         for (int j = 0; j <= MAX_PATTERN; j++) begin
            if (j >= (2 << l)) begin
               g_lv[l+1][j] = g_lv[l][j] | (p_lv[l][j] & g_lv[l][j - (2 << l)]);
               p_lv[l+1][j] = p_lv[l][j] & p_lv[l][j - (2 << l)];
            end else begin
               g_lv[l+1][j] = g_lv[l][j];
               p_lv[l+1][j] = p_lv[l][j];
            end
         end
      end
      row_in = g_lv[LEVELS];
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         row_ff       <= (MAX_PATTERN + 1)'(1);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            row_ff <= row_in;
         end
      end
   end

   // Capture result fields and write the pattern byte
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_matched_ff <= row_in[head_len] && !head.lead;
         rsp_status_ff  <= head.status;
         rsp_count_ff   <= count_ext[5:0];
         if (head.store_wr) begin
            pat_ff[widx] <= head.ch;
         end
      end
   end

   `WSRM_CHECK(a_star_never_matches, clock, reset,
      (rsp_valid_ff && rsp_status_ff == wsrm_pkg::STATUS_STAR) |-> !rsp_matched_ff)
   `WSRM_CHECK(a_start_sets_origin, clock, reset,
      (pop && head.op == wsrm_pkg::ROW_START) |=> row_ff[0])
   `WSRM_CHECK(a_step_clears_origin, clock, reset,
      (pop && head.op == wsrm_pkg::ROW_STEP) |=> !row_ff[0])

endmodule

// ===== hdl/wildcard_star_regex_matcher.sv =====
// Top level of the streaming wildcard and star pattern matcher.
//
//   channel  direction  payload
//   req_*    in         tuser = cmd[1:0], tdata = ch[7:0]
//   rsp_*    out        tdata = matched, status[1:0], pattern_count[5:0], zero pad
//
// Each item yields one result; the row engine resolves a whole item combinationally,
// so the block sustains one item per cycle when the result side keeps up.
// Results are registered: queue slot written at accept, result register loaded at pop.
// A two-entry queue separates the decoder from the row engine; a stalled result
// stops the engine, and the decoder keeps taking items until the queue fills.
// Reset is synchronous: pattern length zero, row origin set, queue and result empty.
module wildcard_star_regex_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch[7:0]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // matched, status[2:1], pattern_count[8:3], zero
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int Q_W   = LEN_W + $bits(wsrm_pkg::item_type);

   logic                 push, pop, q_empty, q_full;
   wsrm_pkg::item_type   push_item, head_item;
   logic [LEN_W-1:0]     push_len, head_len;
   logic [Q_W-1:0]       head_data;

   wsrm_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item),
      .push_len   (push_len)
   );

   wsrm_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_len, push_item}),
      .pop       (pop),
      .head_data (head_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Split the queue head back into length and item
   assign head_item = wsrm_pkg::item_type'(head_data[$bits(wsrm_pkg::item_type)-1:0]);
   assign head_len  = head_data[Q_W-1:$bits(wsrm_pkg::item_type)];

   wsrm_back #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (head_item),
      .head_len   (head_len),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
